FILE: sv/skt_pkg.sv
// Shared types and codes for the sorted key table.
// Holds the request and response payload structs, operation and status codes,
// and the sequencer state type. No dependencies.
`default_nettype none

package skt_pkg;

  // Operation codes carried in req_type
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  // Response status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  // Fixed field widths of the payloads
  localparam int unsigned KEY_W   = 16;
  localparam int unsigned RANK_W  = 6;
  localparam int unsigned COUNT_W = 7;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [RANK_W-1:0]  rank;
    logic [COUNT_W-1:0] entry_count;
  } res_t;

  // Request sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_SHUP,
    S_INS,
    S_SHDN,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

FILE: sv/skt_ram.sv
// Key storage for the sorted key table: one write port, one read port with
// registered read data. Uses skt_pkg for the key width.
`default_nettype none

module skt_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [AW-1:0]             wr_addr,
  input  wire logic [skt_pkg::KEY_W-1:0] wr_data,
  input  wire logic [AW-1:0]             rd_addr,
  output logic      [skt_pkg::KEY_W-1:0] rd_data
);

  logic [skt_pkg::KEY_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: sv/sorted_key_table.sv
// Sorted key table: an ascending set of unique 16-bit keys held in one RAM.
// Depends on skt_pkg (payload types, codes, states) and skt_ram (key storage).
//
// Usage:
//   Requests arrive on in_valid/in_ready/in_data (req_type, key); each one
//   yields exactly one response on out_valid/out_ready/out_data (status, rank,
//   entry_count). Keys sit sorted in RAM entries 0..count-1, rank = index.
// Sequencing:
//   One request at a time. A request scans the RAM from entry 0 until it
//   meets a key not below the request key or the end of the table, one
//   read per cycle. An insert then moves the larger keys up one entry a
//   cycle and writes the key; a delete moves them down. The response is then
//   loaded into the output register; only then is the next request taken.
// Reset:
//   rst_n (synchronous) empties the table and drops any pending response.
//   RAM contents are not cleared; only entries below the count are read.
// Stalls:
//   The response sits in an output register; a new request is taken while it
//   waits, and a finished request holds until that register is free.
`default_nettype none

module sorted_key_table #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire skt_pkg::req_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output skt_pkg::res_t      out_data
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  skt_pkg::state_t state_r, state_nxt;
  skt_pkg::req_t   req_r, req_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;
  logic            hit_r, hit_nxt;
  logic [CW-1:0]   j_r, j_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [1:0]      status_r, status_nxt;
  logic            out_valid_r, out_valid_nxt;
  skt_pkg::res_t   out_data_r, out_data_nxt;

  // RAM port signals
  logic                      wr_en;
  logic [CW-1:0]             wr_idx;
  logic [skt_pkg::KEY_W-1:0] wr_data;
  logic [CW-1:0]             rd_idx;
  logic [skt_pkg::KEY_W-1:0] rd_data;

  // Index arithmetic
  logic [CW-1:0] pos_inc, cnt_inc, cnt_dec, j_dec, j_dec2, j_inc, j_inc2;
  assign pos_inc = pos_r + 1'b1;
  assign cnt_inc = cnt_r + 1'b1;
  assign cnt_dec = cnt_r - 1'b1;
  assign j_dec   = j_r - 1'b1;
  assign j_dec2  = j_r - 2'd2;
  assign j_inc   = j_r + 1'b1;
  assign j_inc2  = j_r + 2'd2;

  // Output field extension (modulo the field widths)
  logic [CW+skt_pkg::RANK_W-1:0]  rank_ext;
  logic [CW+skt_pkg::COUNT_W-1:0] count_ext;
  assign rank_ext  = {{skt_pkg::RANK_W{1'b0}}, pos_r};
  assign count_ext = {{skt_pkg::COUNT_W{1'b0}}, cnt_r};

  skt_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_idx[AW-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  // Sequencer next state, RAM control and response
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    pos_nxt       = pos_r;
    hit_nxt       = hit_r;
    j_nxt         = j_r;
    cnt_nxt       = cnt_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    in_ready      = 1'b0;
    wr_en         = 1'b0;
    wr_idx        = j_r;
    wr_data       = rd_data;
    rd_idx        = '0;

    // drop the response once transferred
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      skt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt = in_data;
          pos_nxt = '0;
          hit_nxt = 1'b0;
          rd_idx  = '0;
          if (cnt_r == '0) begin
            state_nxt = skt_pkg::S_EXEC;
          end else begin
            state_nxt = skt_pkg::S_SCAN;
          end
        end
      end

      // find the first entry not below the key
      skt_pkg::S_SCAN: begin
        if (rd_data >= req_r.key) begin
          hit_nxt   = (rd_data == req_r.key);
          state_nxt = skt_pkg::S_EXEC;
        end else begin
          pos_nxt = pos_inc;
          rd_idx  = pos_inc;
          if (pos_inc == cnt_r) begin
            state_nxt = skt_pkg::S_EXEC;
          end
        end
      end

      skt_pkg::S_EXEC: begin
        state_nxt = skt_pkg::S_RESP;
        unique case (req_r.req_type)
          skt_pkg::OP_INSERT: begin
            if (cnt_r == CAP_C) begin
              status_nxt = skt_pkg::ST_FULL;
            end else if (hit_r) begin
              status_nxt = skt_pkg::ST_DUP;
            end else if (pos_r == cnt_r) begin
              // append at the end
              wr_en      = 1'b1;
              wr_idx     = pos_r;
              wr_data    = req_r.key;
              cnt_nxt    = cnt_inc;
              status_nxt = skt_pkg::ST_OK;
            end else begin
              j_nxt     = cnt_r;
              rd_idx    = cnt_dec;
              state_nxt = skt_pkg::S_SHUP;
            end
          end
          skt_pkg::OP_DELETE: begin
            if (!hit_r) begin
              status_nxt = skt_pkg::ST_MISS;
            end else if (pos_inc == cnt_r) begin
              cnt_nxt    = cnt_dec;
              status_nxt = skt_pkg::ST_OK;
            end else begin
              j_nxt     = pos_r;
              rd_idx    = pos_inc;
              state_nxt = skt_pkg::S_SHDN;
            end
          end
          skt_pkg::OP_SEARCH: begin
            status_nxt = hit_r ? skt_pkg::ST_OK : skt_pkg::ST_MISS;
          end
          default: begin
            status_nxt = skt_pkg::ST_MISS;
          end
        endcase
      end

      // move larger keys up one entry, top first
      skt_pkg::S_SHUP: begin
        wr_en   = 1'b1;
        wr_idx  = j_r;
        wr_data = rd_data;
        if (j_dec == pos_r) begin
          state_nxt = skt_pkg::S_INS;
        end else begin
          j_nxt  = j_dec;
          rd_idx = j_dec2;
        end
      end

      // place the new key in the opened slot
      skt_pkg::S_INS: begin
        wr_en      = 1'b1;
        wr_idx     = pos_r;
        wr_data    = req_r.key;
        cnt_nxt    = cnt_inc;
        status_nxt = skt_pkg::ST_OK;
        state_nxt  = skt_pkg::S_RESP;
      end

      // move larger keys down one entry to close the gap
      skt_pkg::S_SHDN: begin
        wr_en   = 1'b1;
        wr_idx  = j_r;
        wr_data = rd_data;
        if (j_inc2 == cnt_r) begin
          cnt_nxt    = cnt_dec;
          status_nxt = skt_pkg::ST_OK;
          state_nxt  = skt_pkg::S_RESP;
        end else begin
          j_nxt  = j_inc;
          rd_idx = j_inc2;
        end
      end

      // hold until the output register is free
      skt_pkg::S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = status_r;
          out_data_nxt.rank        = (status_r == skt_pkg::ST_OK) ?
                                     rank_ext[skt_pkg::RANK_W-1:0] : '0;
          out_data_nxt.entry_count = count_ext[skt_pkg::COUNT_W-1:0];
          state_nxt                = skt_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = skt_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skt_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    pos_r      <= pos_nxt;
    hit_r      <= hit_nxt;
    j_r        <= j_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: test/tb_sorted_key_table.sv
// Self-checking testbench for sorted_key_table: directed table, then random traffic.
// Depends on skt_pkg for payload types and codes, and on the sorted_key_table RTL.
// Predicts the sorted key set; responses are checked against it or a typed want.
module tb_sorted_key_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH   = 64;
  localparam int RANDOM_ITEMS  = 1080;
  localparam int MODE_SPAN     = 160;
  localparam int DRAIN_CYCLES  = 2 * TABLE_DEPTH + 30;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Mix of requests in the random part
  typedef enum int {MODE_FILL, MODE_MIXED, MODE_DRAIN} traffic_mode_t;

  // One row of directed stimulus; want is only meaningful when typed is set
  typedef struct packed {
    logic [1:0]                op;
    logic [skt_pkg::KEY_W-1:0] key;
    bit                        typed;
    skt_pkg::res_t             want;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 22;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_ready;
  skt_pkg::req_t in_data   = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  skt_pkg::res_t out_data;

  // Predictor state: keys in ascending order, entries 0..key_total-1
  logic [skt_pkg::KEY_W-1:0] sorted_keys [TABLE_DEPTH];
  int                        key_total = 0;

  skt_pkg::res_t pending_results [$];
  skt_pkg::res_t oldest_result;

  int in_idle_pct  = 35;
  int out_idle_pct = 75;
  int mismatch_count = 0;
  int responses_seen = 0;
  int peak_count     = 0;
  int status_seen [4] = '{0, 0, 0, 0};

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{skt_pkg::OP_SEARCH, 16'h0000, 1'b1, '{skt_pkg::ST_MISS, 6'd0, 7'd0}},
    '{skt_pkg::OP_DELETE, 16'hFFFF, 1'b1, '{skt_pkg::ST_MISS, 6'd0, 7'd0}},
    '{OP_UNUSED,          16'h1234, 1'b1, '{skt_pkg::ST_MISS, 6'd0, 7'd0}},
    '{skt_pkg::OP_INSERT, 16'h0000, 1'b1, '{skt_pkg::ST_OK,   6'd0, 7'd1}},
    '{skt_pkg::OP_INSERT, 16'hFFFF, 1'b1, '{skt_pkg::ST_OK,   6'd1, 7'd2}},
    '{skt_pkg::OP_INSERT, 16'h0000, 1'b1, '{skt_pkg::ST_DUP,  6'd0, 7'd2}},
    '{skt_pkg::OP_INSERT, 16'hFFFF, 1'b1, '{skt_pkg::ST_DUP,  6'd0, 7'd2}},
    '{skt_pkg::OP_SEARCH, 16'hFFFF, 1'b1, '{skt_pkg::ST_OK,   6'd1, 7'd2}},
    '{skt_pkg::OP_INSERT, 16'h8000, 1'b0, '0},
    '{skt_pkg::OP_INSERT, 16'h7FFF, 1'b0, '0},
    '{skt_pkg::OP_INSERT, 16'h0001, 1'b0, '0},
    '{skt_pkg::OP_SEARCH, 16'h8000, 1'b0, '0},
    '{skt_pkg::OP_SEARCH, 16'h1234, 1'b1, '{skt_pkg::ST_MISS, 6'd0, 7'd5}},
    '{skt_pkg::OP_DELETE, 16'h7FFF, 1'b0, '0},
    '{skt_pkg::OP_DELETE, 16'h7FFF, 1'b1, '{skt_pkg::ST_MISS, 6'd0, 7'd4}},
    '{OP_UNUSED,          16'h5555, 1'b1, '{skt_pkg::ST_MISS, 6'd0, 7'd4}},
    '{skt_pkg::OP_DELETE, 16'h0000, 1'b0, '0},
    '{skt_pkg::OP_DELETE, 16'hFFFF, 1'b0, '0},
    '{skt_pkg::OP_SEARCH, 16'hAAAA, 1'b1, '{skt_pkg::ST_MISS, 6'd0, 7'd2}},
    '{skt_pkg::OP_DELETE, 16'h8000, 1'b0, '0},
    '{skt_pkg::OP_DELETE, 16'h0001, 1'b0, '0},
    '{skt_pkg::OP_SEARCH, 16'h0001, 1'b1, '{skt_pkg::ST_MISS, 6'd0, 7'd0}}
  };

  sorted_key_table #(
    .CAPACITY (TABLE_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one request to the key set and return the response it should get
  function automatic skt_pkg::res_t apply_request(skt_pkg::req_t r);
    int            pos;
    bit            hit;
    skt_pkg::res_t res;
    pos = 0;
    while (pos < key_total && sorted_keys[pos] < r.key) pos++;
    hit = (pos < key_total) && (sorted_keys[pos] == r.key);
    res.status = skt_pkg::ST_MISS;
    res.rank   = '0;
    case (r.req_type)
      skt_pkg::OP_INSERT: begin
        // room is checked before the key, so a full table wins over a duplicate
        if (key_total >= TABLE_DEPTH) begin
          res.status = skt_pkg::ST_FULL;
        end else if (hit) begin
          res.status = skt_pkg::ST_DUP;
        end else begin
          for (int i = key_total; i > pos; i--) sorted_keys[i] = sorted_keys[i-1];
          sorted_keys[pos] = r.key;
          key_total++;
          res.status = skt_pkg::ST_OK;
          res.rank   = skt_pkg::RANK_W'(pos);
        end
      end
      skt_pkg::OP_DELETE: begin
        if (hit) begin
          for (int i = pos; i + 1 < key_total; i++) sorted_keys[i] = sorted_keys[i+1];
          key_total--;
          res.status = skt_pkg::ST_OK;
          res.rank   = skt_pkg::RANK_W'(pos);
        end
      end
      skt_pkg::OP_SEARCH: begin
        if (hit) begin
          res.status = skt_pkg::ST_OK;
          res.rank   = skt_pkg::RANK_W'(pos);
        end
      end
      default: ;
    endcase
    res.entry_count = skt_pkg::COUNT_W'(key_total);
    return res;
  endfunction

  // Pick a key: one held with hit_pct chance, sometimes an extreme, else anything
  function automatic logic [skt_pkg::KEY_W-1:0] pick_key(int hit_pct);
    int roll;
    roll = $urandom_range(99);
    if (key_total > 0 && roll < hit_pct) return sorted_keys[$urandom_range(key_total - 1)];
    if (roll < hit_pct + 5) return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    return skt_pkg::KEY_W'($urandom_range(65535));
  endfunction

  task automatic log_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Drive one request from a falling edge and hold it until the transfer
  task automatic drive_request(skt_pkg::req_t r, bit typed, skt_pkg::res_t want);
    skt_pkg::res_t predicted;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    predicted = apply_request(r);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // Receiver stalls at random
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Check each response against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      responses_seen++;
      status_seen[out_data.status]++;
      if (int'(out_data.entry_count) > peak_count) peak_count = out_data.entry_count;
      if (pending_results.size() == 0) begin
        log_mismatch("response with none pending", int'(out_data), 0);
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_data.status != oldest_result.status)
          log_mismatch("status", out_data.status, oldest_result.status);
        if (out_data.rank != oldest_result.rank)
          log_mismatch("rank", out_data.rank, oldest_result.rank);
        if (out_data.entry_count != oldest_result.entry_count)
          log_mismatch("entry_count", out_data.entry_count, oldest_result.entry_count);
      end
    end
  end

  initial begin : stimulus
    skt_pkg::req_t req;
    traffic_mode_t mode;
    int            counted;
    int            roll;
    int            hit_pct;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table: extremes, duplicates, misses, unused code
    foreach (directed_rows[i]) begin
      req.req_type = directed_rows[i].op;
      req.key      = directed_rows[i].key;
      drive_request(req, directed_rows[i].typed, directed_rows[i].want);
    end

    // Random traffic, cycling through fill, mixed and drain so the table
    // repeatedly reaches full and empty
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted < RANDOM_ITEMS / 3) begin
        in_idle_pct  = 35;
        out_idle_pct = 75;
      end else if (counted < 2 * RANDOM_ITEMS / 3) begin
        in_idle_pct  = 75;
        out_idle_pct = 35;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      mode = traffic_mode_t'((counted / MODE_SPAN) % 3);
      roll = $urandom_range(99);
      case (mode)
        MODE_FILL: begin
          hit_pct = 30;
          req.req_type = (roll < 85) ? skt_pkg::OP_INSERT :
                         (roll < 90) ? skt_pkg::OP_DELETE :
                         (roll < 97) ? skt_pkg::OP_SEARCH : OP_UNUSED;
        end
        MODE_MIXED: begin
          hit_pct = 50;
          req.req_type = (roll < 35) ? skt_pkg::OP_INSERT :
                         (roll < 65) ? skt_pkg::OP_DELETE :
                         (roll < 97) ? skt_pkg::OP_SEARCH : OP_UNUSED;
        end
        default: begin
          hit_pct = 85;
          req.req_type = (roll < 10) ? skt_pkg::OP_INSERT :
                         (roll < 85) ? skt_pkg::OP_DELETE :
                         (roll < 97) ? skt_pkg::OP_SEARCH : OP_UNUSED;
        end
      endcase
      req.key = pick_key(hit_pct);
      drive_request(req, 1'b0, '0);
      if (req.req_type != OP_UNUSED) counted++;
    end
    in_valid <= 1'b0;

    // Drain outstanding responses, then allow one more full request time
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d responses: %0d ok, %0d duplicate, %0d not found, %0d full",
             responses_seen, status_seen[skt_pkg::ST_OK], status_seen[skt_pkg::ST_DUP],
             status_seen[skt_pkg::ST_MISS], status_seen[skt_pkg::ST_FULL]);
    $display("peak occupancy %0d of %0d keys, %0d field errors",
             peak_count, TABLE_DEPTH, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop if the handshakes hang
  initial begin
    #10ms;
    $display("timeout with %0d responses outstanding", pending_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
